// ----- sv/cba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting block allocator package
// Request codes, status codes and field widths shared by the allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 5;
    localparam int BYTE_W = 17;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESIZE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FND  = 2'd2;

    typedef logic [BYTE_W-1:0] bytes_t;

endpackage

// ----- sv/compacting_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting block allocator
// Ordered block table in two memories with registered reads, walked by a sequencer.
// ----------------------------------------------------------------------------
// Alloc, clear and a missing index answer straight from dispatch; query reads its
// entry first; free and resize also move each later entry, freeing the last entry
// above index zero rereads the entry below it for the new end, and a compaction
// pass walks every table entry and then dispatches the alloc or resize again.
// Requests are handled one at a time: a new one is accepted only after the
// previous response is registered, which waits while an older one is held.
// Reset: aresetn is synchronous; the table empties at once, no clearing pass.
module compacting_block_allocator_unit #(
    parameter int MAX_BLOCKS       = 32,
    parameter int REGION_BYTES_MAX = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], block_index[7:3], length[24:8], zero pad[31:25]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_index[6:2], block_offset[23:7], block_length[40:24],
    // used_bytes[57:41], free_bytes[74:58], zero pad[79:75]
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    import cba_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;
    localparam int CAP_MAX_I = (REGION_BYTES_MAX > 131071) ? 131071 : REGION_BYTES_MAX;
    localparam int CAP_RST_I = (REGION_BYTES_MAX > 65536) ? 65536 : REGION_BYTES_MAX;
    localparam bytes_t CAP_MAX = BYTE_W'(CAP_MAX_I);
    localparam bytes_t CAP_RST = BYTE_W'(CAP_RST_I);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_BLOCKS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_IDX    = 4'd2;
    localparam logic [3:0] S_FR_RD  = 4'd3;
    localparam logic [3:0] S_FR_WR  = 4'd4;
    localparam logic [3:0] S_RS_RD  = 4'd5;
    localparam logic [3:0] S_RS_WR  = 4'd6;
    localparam logic [3:0] S_CMP_RD = 4'd7;
    localparam logic [3:0] S_CMP_WR = 4'd8;
    localparam logic [3:0] S_END_RD = 4'd9;
    localparam logic [3:0] S_END_CA = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    bytes_t off_mem [MAX_BLOCKS];
    bytes_t len_mem [MAX_BLOCKS];
    bytes_t rd_off, rd_len;

    logic [3:0]        st_reg, st_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    bytes_t            len_reg, len_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    bytes_t            acc_reg, acc_next;
    bytes_t            dist_reg, dist_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              gaps_reg, gaps_next;
    logic              cmp_reg, cmp_next;
    bytes_t            end_reg, end_next;
    bytes_t            cap_reg;
    logic [STAT_W-1:0] stat_reg, stat_next;
    bytes_t            boff_reg, boff_next;
    bytes_t            blen_reg, blen_next;
    logic              mv_reg, mv_next;
    logic [79:0]       mdata_reg, mdata_next;

    logic [AW-1:0] ra, wa;
    logic          we_off, we_len;
    bytes_t        wd_off, wd_len;
    bytes_t        free_b, new_off, need;
    logic [XW-1:0] idx_x, cnt_x, ptr_x;
    logic [AW-1:0] idx_a;

    assign s_tready  = (st_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;

    assign free_b = (end_reg >= cap_reg) ? '0 : cap_reg - end_reg;
    assign idx_x  = XW'(idx_reg);
    assign cnt_x  = XW'(cnt_reg);
    assign ptr_x  = XW'(ptr_reg);
    assign idx_a  = AW'(idx_reg);
    assign need   = len_reg - rd_len;

    always_comb begin
        st_next    = st_reg;
        func_next  = func_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        acc_next   = acc_reg;
        dist_next  = dist_reg;
        cnt_next   = cnt_reg;
        gaps_next  = gaps_reg;
        cmp_next   = cmp_reg;
        end_next   = end_reg;
        stat_next  = stat_reg;
        boff_next  = boff_reg;
        blen_next  = blen_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        ra         = ptr_reg;
        wa         = ptr_reg;
        we_off     = 1'b0;
        we_len     = 1'b0;
        wd_off     = rd_off;
        wd_len     = rd_len;
        new_off    = rd_off + dist_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (st_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tdata[2:0];
                    idx_next  = s_tdata[7:3];
                    len_next  = s_tdata[24:8];
                    stat_next = STAT_OK;
                    boff_next = '0;
                    blen_next = '0;
                    cmp_next  = 1'b0;
                    st_next   = S_DISP;
                end
            end
            S_DISP: begin
                ra = idx_a;
                case (func_reg)
                    FUNC_ALLOC: begin
                        if (cnt_x >= MAX_X) begin
                            stat_next = STAT_NO_SPACE;
                            st_next   = S_DONE;
                        end else if (len_reg <= free_b) begin
                            wa        = AW'(cnt_reg);
                            we_off    = 1'b1;
                            we_len    = 1'b1;
                            wd_off    = end_reg;
                            wd_len    = len_reg;
                            boff_next = end_reg;
                            blen_next = len_reg;
                            cnt_next  = cnt_reg + 1'b1;
                            end_next  = end_reg + len_reg;
                            st_next   = S_DONE;
                        end else if (!cmp_reg && gaps_reg && cnt_reg != '0) begin
                            ptr_next = '0;
                            acc_next = '0;
                            cmp_next = 1'b1;
                            st_next  = S_CMP_RD;
                        end else begin
                            gaps_next = 1'b0;
                            stat_next = STAT_NO_SPACE;
                            st_next   = S_DONE;
                        end
                    end
                    FUNC_FREE, FUNC_RESIZE, FUNC_QUERY: begin
                        if (idx_x >= cnt_x) begin
                            stat_next = STAT_NOT_FND;
                            st_next   = S_DONE;
                        end else begin
                            st_next = S_IDX;
                        end
                    end
                    FUNC_CLEAR: begin
                        cnt_next = '0;
                        end_next = '0;
                        st_next  = S_DONE;
                    end
                    default: begin
                        st_next = S_DONE;
                    end
                endcase
            end
            S_IDX: begin
                case (func_reg)
                    FUNC_FREE: begin
                        boff_next = rd_off;
                        blen_next = rd_len;
                        gaps_next = 1'b1;
                        ptr_next  = idx_a;
                        if (idx_x + 1'b1 < cnt_x) begin
                            st_next = S_FR_RD;
                        end else begin
                            cnt_next = cnt_reg - 1'b1;
                            if (idx_reg == '0) begin
                                end_next = '0;
                                st_next  = S_DONE;
                            end else begin
                                ptr_next = idx_a - 1'b1;
                                st_next  = S_END_RD;
                            end
                        end
                    end
                    FUNC_RESIZE: begin
                        if (len_reg > rd_len && need > free_b) begin
                            if (!cmp_reg && gaps_reg && cnt_reg != '0) begin
                                ptr_next = '0;
                                acc_next = '0;
                                cmp_next = 1'b1;
                                st_next  = S_CMP_RD;
                            end else begin
                                gaps_next = 1'b0;
                                stat_next = STAT_NO_SPACE;
                                boff_next = rd_off;
                                blen_next = rd_len;
                                st_next   = S_DONE;
                            end
                        end else begin
                            wa        = idx_a;
                            we_len    = 1'b1;
                            wd_len    = len_reg;
                            boff_next = rd_off;
                            blen_next = len_reg;
                            acc_next  = rd_off + len_reg;
                            if (idx_x + 1'b1 < cnt_x) begin
                                ptr_next = idx_a + 1'b1;
                                st_next  = S_RS_RD;
                            end else begin
                                end_next = rd_off + len_reg;
                                st_next  = S_DONE;
                            end
                        end
                    end
                    default: begin
                        boff_next = rd_off;
                        blen_next = rd_len;
                        st_next   = S_DONE;
                    end
                endcase
            end
            S_FR_RD: begin
                ra      = ptr_reg + 1'b1;
                st_next = S_FR_WR;
            end
            S_FR_WR: begin
                we_off = 1'b1;
                we_len = 1'b1;
                if (ptr_x + 2'd2 < cnt_x) begin
                    ptr_next = ptr_reg + 1'b1;
                    st_next  = S_FR_RD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    st_next  = S_DONE;
                end
            end
            S_RS_RD: begin
                st_next = S_RS_WR;
            end
            S_RS_WR: begin
                // The first moved block lands right at the resized block's end.
                if (ptr_reg == idx_a + 1'b1) begin
                    dist_next = acc_reg - rd_off;
                    new_off   = acc_reg;
                end
                we_off = 1'b1;
                wd_off = new_off;
                if (ptr_x + 1'b1 < cnt_x) begin
                    ptr_next = ptr_reg + 1'b1;
                    st_next  = S_RS_RD;
                end else begin
                    end_next = new_off + rd_len;
                    st_next  = S_DONE;
                end
            end
            S_CMP_RD: begin
                st_next = S_CMP_WR;
            end
            S_CMP_WR: begin
                we_off   = 1'b1;
                wd_off   = acc_reg;
                acc_next = acc_reg + rd_len;
                if (ptr_x + 1'b1 < cnt_x) begin
                    ptr_next = ptr_reg + 1'b1;
                    st_next  = S_CMP_RD;
                end else begin
                    end_next  = acc_reg + rd_len;
                    gaps_next = 1'b0;
                    st_next   = S_DISP;
                end
            end
            S_END_RD: begin
                st_next = S_END_CA;
            end
            S_END_CA: begin
                end_next = rd_off + rd_len;
                st_next  = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {5'd0, free_b, end_reg, blen_reg, boff_reg,
                                  ((func_reg == FUNC_ALLOC && stat_reg == STAT_OK) ||
                                   (func_reg inside {FUNC_FREE, FUNC_RESIZE, FUNC_QUERY})) ?
                                      ((func_reg == FUNC_ALLOC) ? IDX_W'(cnt_reg - 1'b1)
                                                                : idx_reg) : '0,
                                  stat_reg};
                    st_next    = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_off) begin
            off_mem[wa] <= wd_off;
        end
        if (we_len) begin
            len_mem[wa] <= wd_len;
        end
        rd_off <= off_mem[ra];
        rd_len <= len_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            cnt_reg  <= '0;
            gaps_reg <= 1'b0;
            end_reg  <= '0;
            cap_reg  <= CAP_RST;
            mv_reg   <= 1'b0;
            cmp_reg  <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            gaps_reg <= gaps_next;
            end_reg  <= end_next;
            mv_reg   <= mv_next;
            cmp_reg  <= cmp_next;
            if (cfg_valid) begin
                cap_reg <= (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        idx_reg   <= idx_next;
        len_reg   <= len_next;
        ptr_reg   <= ptr_next;
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
        stat_reg  <= stat_next;
        boff_reg  <= boff_next;
        blen_reg  <= blen_next;
        mdata_reg <= mdata_next;
    end

    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (end_reg == '0))
        else $error("empty table with nonzero end offset");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (XW'(cnt_reg) <= MAX_X))
        else $error("block count above table size");
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (st_reg == S_DISP))
        else $error("accepted request not dispatched");

endmodule

// ----- bench/compacting_block_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting block allocator testbench
// Drives alloc, free, resize, query and clear requests through the request
// stream, predicts every response with a behavioral table model, and
// compares each response field by field under random back-pressure.
// ----------------------------------------------------------------------------
module compacting_block_allocator_unit_tb;
    import cba_pkg::*;

    localparam int NBLK     = 32;
    localparam int REG_MAX  = 65536;
    localparam int LIMIT    = 2000000;

    class alloc_scoreboard;
        int unsigned capacity;
        int unsigned offs[NBLK];
        int unsigned lens[NBLK];
        int unsigned count;
        bit          gaps;
        logic [79:0] pending_q[$];
        int          errors;

        function new();
            capacity = REG_MAX;
            count    = 0;
            gaps     = 0;
            errors   = 0;
        endfunction

        function void set_capacity(logic [16:0] v);
            capacity = (v > REG_MAX) ? REG_MAX : v;
        endfunction

        function int unsigned end_of_table();
            if (count == 0) return 0;
            return offs[count-1] + lens[count-1];
        endfunction

        function int unsigned room_left();
            int unsigned u;
            u = end_of_table();
            return (u >= capacity) ? 0 : capacity - u;
        endfunction

        function bit reserve(int unsigned need);
            int unsigned pos;
            if (need <= room_left()) return 1;
            if (gaps && count != 0) begin
                pos = 0;
                for (int i = 0; i < count; i++) begin
                    offs[i] = pos;
                    pos += lens[i];
                end
            end
            gaps = 0;
            return need <= room_left();
        endfunction

        function void note_request(logic [2:0] func, logic [4:0] idx, logic [16:0] len);
            logic [1:0]  st;
            int unsigned ridx, boff, blen, shift_amt;
            int unsigned ue, fb;
            logic [79:0] rsp_word;
            st = STAT_OK; ridx = 0; boff = 0; blen = 0;
            case (func)
                FUNC_ALLOC: begin
                    if (count >= NBLK || !reserve(len)) begin
                        st = STAT_NO_SPACE;
                    end else begin
                        boff = end_of_table();
                        blen = len;
                        ridx = count;
                        offs[count] = boff;
                        lens[count] = blen;
                        count++;
                    end
                end
                FUNC_FREE, FUNC_RESIZE, FUNC_QUERY: begin
                    ridx = idx;
                    if (idx >= count) begin
                        st = STAT_NOT_FND;
                    end else if (func == FUNC_FREE) begin
                        boff = offs[idx];
                        blen = lens[idx];
                        for (int i = idx; i + 1 < count; i++) begin
                            offs[i] = offs[i+1];
                            lens[i] = lens[i+1];
                        end
                        count--;
                        gaps = 1;
                    end else begin
                        if (func == FUNC_RESIZE) begin
                            if (len > lens[idx] && !reserve(len - lens[idx])) begin
                                st = STAT_NO_SPACE;
                            end else begin
                                lens[idx] = len;
                                if (idx + 1 < count) begin
                                    // Wrapping subtraction yields a signed shift.
                                    shift_amt = offs[idx] + len - offs[idx+1];
                                    for (int i = idx + 1; i < count; i++) offs[i] += shift_amt;
                                end
                            end
                        end
                        boff = offs[idx];
                        blen = lens[idx];
                    end
                end
                FUNC_CLEAR: count = 0;
                default: ;
            endcase
            ue = end_of_table();
            fb = room_left();
            rsp_word = {5'd0, fb[16:0], ue[16:0], blen[16:0], boff[16:0], ridx[4:0], st};
            pending_q = {pending_q, rsp_word};
        endfunction

        function void check_result(logic [79:0] got);
            logic [79:0] exp;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got[1:0] !== exp[1:0]) begin
                $display("%0t: status exp %0d got %0d", $time, exp[1:0], got[1:0]);
                errors++;
            end
            if (got[6:2] !== exp[6:2]) begin
                $display("%0t: result_index exp %0d got %0d", $time, exp[6:2], got[6:2]);
                errors++;
            end
            if (got[23:7] !== exp[23:7]) begin
                $display("%0t: block_offset exp %0d got %0d", $time, exp[23:7], got[23:7]);
                errors++;
            end
            if (got[40:24] !== exp[40:24]) begin
                $display("%0t: block_length exp %0d got %0d", $time, exp[40:24], got[40:24]);
                errors++;
            end
            if (got[57:41] !== exp[57:41]) begin
                $display("%0t: used_bytes exp %0d got %0d", $time, exp[57:41], got[57:41]);
                errors++;
            end
            if (got[74:58] !== exp[74:58]) begin
                $display("%0t: free_bytes exp %0d got %0d", $time, exp[74:58], got[74:58]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    alloc_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    bit hold_done   = 0;
    int item_no     = 0;
    int cycle_cnt   = 0;

    compacting_block_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tdata[2:0], s_tdata[7:3], s_tdata[24:8]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // The receiver process owns the long hold-off count.
    always @(negedge aclk) begin
        if (!hold_done && item_no >= 1400) begin
            hold_cycles = 2000;
            hold_done   = 1;
        end
        if (hold_cycles > 0) begin
            m_tready    = 0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_req(logic [2:0] func, logic [4:0] idx, logic [16:0] len);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 0;
        end
        @(negedge aclk);
        s_tvalid = 1;
        s_tdata  = {7'd0, len, idx, func};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_capacity(logic [16:0] v);
        @(negedge aclk);
        s_tvalid = 0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (4 * NBLK + 10) @(negedge aclk);
        cfg_valid = 1;
        cfg_data  = v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_capacity(v);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic random_req();
        int          pick;
        logic [16:0] len;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0) len = 17'($urandom_range(0, 17'h1FFFF));
        else len = 17'($urandom_range(0, sb.capacity / 6 + 1));
        if (pick < 40)      send_req(FUNC_ALLOC, 5'($urandom_range(31)), len);
        else if (pick < 62) send_req(FUNC_FREE, 5'($urandom_range(0, sb.count + 2)), len);
        else if (pick < 82) send_req(FUNC_RESIZE, 5'($urandom_range(0, sb.count + 2)), len);
        else if (pick < 94) send_req(FUNC_QUERY, 5'($urandom_range(31)), len);
        else if (pick < 97) send_req(FUNC_CLEAR, 5'($urandom_range(31)), len);
        else                send_req(3'($urandom_range(5, 7)), 5'($urandom_range(31)), len);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        write_capacity(17'd65536);
        send_req(FUNC_ALLOC, 5'd0, 17'd0);
        send_req(FUNC_ALLOC, 5'd0, 17'd65536);
        send_req(FUNC_ALLOC, 5'd0, 17'd1);
        send_req(FUNC_QUERY, 5'd1, 17'd0);
        send_req(FUNC_QUERY, 5'd31, 17'd0);
        send_req(FUNC_RESIZE, 5'd1, 17'd100);
        send_req(FUNC_FREE, 5'd0, 17'd0);
        send_req(FUNC_RESIZE, 5'd0, 17'd65536);
        send_req(FUNC_FREE, 5'd31, 17'd0);
        send_req(FUNC_ALLOC, 5'd0, 17'h1FFFF);
        send_req(FUNC_CLEAR, 5'd0, 17'd0);
        send_req(3'd5, 5'd31, 17'h1FFFF);
        send_req(3'd6, 5'd0, 17'd0);
        send_req(3'd7, 5'd0, 17'd0);
        // Fill the table past its limit, then punch a gap to force compaction.
        for (int i = 0; i < NBLK + 1; i++) send_req(FUNC_ALLOC, 5'd0, 17'd2000);
        send_req(FUNC_FREE, 5'd3, 17'd0);
        send_req(FUNC_ALLOC, 5'd0, 17'd3000);
        send_req(FUNC_RESIZE, 5'd5, 17'd4000);
        send_req(FUNC_CLEAR, 5'd0, 17'd0);

        write_capacity(17'd0);
        send_req(FUNC_ALLOC, 5'd0, 17'd0);
        send_req(FUNC_ALLOC, 5'd0, 17'd1);
        send_req(FUNC_RESIZE, 5'd0, 17'd1);

        for (int n = 0; n < 2000; n++) begin
            item_no = n;
            if (n == 0)    write_capacity(17'd1000);
            if (n == 500)  write_capacity(17'h1FFFF);
            if (n == 1000) write_capacity(17'($urandom_range(256, 65536)));
            if (n == 1500) write_capacity(17'd65536);
            if (n == 1950) write_capacity(17'd1);
            if (n < 667) begin
                tx_idle_pct = 16; rx_idle_pct = 87;
            end else if (n < 1333) begin
                tx_idle_pct = 87; rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            random_req();
        end
        @(negedge aclk);
        s_tvalid = 0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (4 * NBLK + 10) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
